// ===== src/send_packet_ring_queue_macros.svh =====
// Assertion macros shared by the packet ring queue modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef SEND_PACKET_RING_QUEUE_MACROS_SVH
`define SEND_PACKET_RING_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// Shared types and constants of the packet ring queue.
// No dependencies; the front end, job queue, back end and top level import this package.
package spq_pkg;

  localparam int SLOTS_DEF        = 4;
  localparam int PACKET_BYTES_DEF = 64;
  localparam int SLOT_IDX_W       = 4;   // enough for the largest ring of 16 slots
  localparam int LEN_W            = 7;
  localparam int BYTE_W           = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic                  is_pop;
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [LEN_W-1:0]      length;
    logic [BYTE_W-1:0]     channel;
    logic                  waiting;
  } job_t;

  // Byte write into the packet store.
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] slot;
    logic [LEN_W-1:0]      pos;
    logic [BYTE_W-1:0]     data;
  } mem_wr_t;

endpackage

// ===== src/spq_in_if.sv =====
// Request channel of the packet ring queue: valid/ready plus the request fields.
// No dependencies.
interface spq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       closes_packet;
  logic [7:0] channel_tag;

  modport source (output valid, op, data_byte, closes_packet, channel_tag, input ready);
  modport sink   (input valid, op, data_byte, closes_packet, channel_tag, output ready);
endinterface

// ===== src/spq_out_if.sv =====
// Result channel of the packet ring queue: valid/ready plus the result fields.
// No dependencies.
interface spq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic [7:0] out_channel;
  logic [6:0] out_length;
  logic       packet_waiting;
  logic       last_of_run;

  modport source (output valid, status, out_byte, out_channel, out_length, packet_waiting,
                  last_of_run, input ready);
  modport sink   (input valid, status, out_byte, out_channel, out_length, packet_waiting,
                  last_of_run, output ready);
endinterface

// ===== src/spq_front.sv =====
// Front end: accepts requests, keeps the ring pointers and slot descriptors,
// writes pushed bytes and issues jobs. Depends on spq_pkg, spq_in_if and the macros.
`include "send_packet_ring_queue_macros.svh"

module spq_front import spq_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  spq_in_if.sink  in_if,
  input  logic    q_full_i,
  output logic    q_push_o,
  output job_t    q_job_o,
  output mem_wr_t wr_o,
  input  logic    done_i
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0]    SLOTS_C   = CW'(SLOTS);
  localparam logic [LEN_W-1:0] PB_C      = LEN_W'(PACKET_BYTES);
  localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);

  logic [SW-1:0]     write_slot_r, write_slot_nxt;
  logic [SW-1:0]     read_slot_r, read_slot_nxt;
  logic [CW-1:0]     stored_r, stored_nxt;
  logic [CW-1:0]     pending_r, pending_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  len_mem_r [SLOTS];
  logic [BYTE_W-1:0] chan_mem_r [SLOTS];

  logic [CW:0]       occupied;
  logic              hazard;
  logic              accept;
  logic              fill_room;
  logic [LEN_W-1:0]  fill_inc;
  logic [LEN_W-1:0]  head_len;
  logic              desc_we;
  logic              byte_we;
  logic              pop_enq;
  job_t              job;
  job_t              chk_job;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  // A push may land in a slot that the back end is still reading out; hold
  // every request until that read has finished.
  assign occupied    = {1'b0, stored_r} + {1'b0, pending_r};
  assign hazard      = (stored_r != SLOTS_C) && (occupied >= {1'b0, SLOTS_C});
  assign in_if.ready = !q_full_i && !hazard;
  assign accept      = in_if.valid && in_if.ready;

  assign fill_room = fill_r < PB_C;
  assign fill_inc  = fill_r + LEN_W'(fill_room);
  assign head_len  = len_mem_r[read_slot_r];

  always_comb begin
    chk_job         = '0;
    chk_job.status  = (stored_r != '0) ? ST_OK : ST_EMPTY;
    chk_job.waiting = (stored_r != '0);

    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    stored_nxt     = stored_r;
    fill_nxt       = fill_r;
    desc_we        = 1'b0;
    byte_we        = 1'b0;
    pop_enq        = 1'b0;
    job            = '0;

    case (in_if.op)
      OP_PUSH: begin
        if (stored_r == SLOTS_C) begin
          job.status  = ST_FULL;
          job.waiting = 1'b1;
        end else begin
          byte_we = fill_room;
          if (in_if.closes_packet) begin
            desc_we        = 1'b1;
            write_slot_nxt = next_slot(write_slot_r);
            stored_nxt     = stored_r + CW'(1);
            fill_nxt       = '0;
          end else begin
            fill_nxt = fill_inc;
          end
          job.status  = ST_OK;
          job.waiting = (stored_nxt != '0);
        end
      end
      OP_POP: begin
        if (stored_r == '0) begin
          job.status = ST_EMPTY;
        end else begin
          stored_nxt    = stored_r - CW'(1);
          read_slot_nxt = next_slot(read_slot_r);
          job.status    = ST_OK;
          job.channel   = chan_mem_r[read_slot_r];
          job.waiting   = (stored_nxt != '0);
          if (head_len != '0) begin
            job.is_pop = 1'b1;
            job.slot   = SLOT_IDX_W'(read_slot_r);
            job.length = head_len;
            pop_enq    = 1'b1;
          end
        end
      end
      OP_CHECK: job = chk_job;
      default:  job = chk_job;
    endcase
  end

  always_comb begin
    pending_nxt = pending_r;
    if (accept && pop_enq && !done_i) begin
      pending_nxt = pending_r + CW'(1);
    end else if (done_i && !(accept && pop_enq)) begin
      pending_nxt = pending_r - CW'(1);
    end
  end

  assign q_push_o = accept;
  assign q_job_o  = job;

  assign wr_o.en   = accept && byte_we;
  assign wr_o.slot = SLOT_IDX_W'(write_slot_r);
  assign wr_o.pos  = fill_r;
  assign wr_o.data = in_if.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      read_slot_r  <= '0;
      stored_r     <= '0;
      pending_r    <= '0;
      fill_r       <= '0;
    end else begin
      pending_r <= pending_nxt;
      if (accept) begin
        write_slot_r <= write_slot_nxt;
        read_slot_r  <= read_slot_nxt;
        stored_r     <= stored_nxt;
        fill_r       <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && desc_we) begin
      len_mem_r[write_slot_r]  <= fill_inc;
      chan_mem_r[write_slot_r] <= in_if.channel_tag;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_ring_bound, (occupied <= {1'b0, SLOTS_C}), "ring over-committed")
  `SPQ_ASSERT_IMPL(a_done_pending, done_i, pending_r != '0, "read-out done with none pending")
  `SPQ_ASSERT_ALWAYS(a_fill_bound, fill_r <= PB_C, "fill position beyond slot size")

endmodule

// ===== src/spq_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on spq_pkg.
module spq_queue import spq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  job_t          entry_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_r == NW'(QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign job_o   = entry_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= job_i;
    end
  end

endmodule

// ===== src/spq_back.sv =====
// Back end: holds the packet byte store, streams popped packets and
// registers every result. Depends on spq_pkg, spq_out_if and the macros.
`include "send_packet_ring_queue_macros.svh"

module spq_back import spq_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_wr_t    wr_i,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  output logic       done_o,
  spq_out_if.source  out_if
);

  localparam int SW        = $clog2(SLOTS);
  localparam int MEM_DEPTH = SLOTS * PACKET_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic {BK_IDLE, BK_STREAM} bk_state_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] channel;
    logic [LEN_W-1:0]  length;
    logic              waiting;
    logic              last;
    logic              use_mem;
  } stage_t;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  bk_state_t         state_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic [SW-1:0]     cur_slot_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] chan_r;
  logic              wait_r;
  logic [LEN_W-1:0]  idx_r;
  stage_t            s1_r;
  logic [BYTE_W-1:0] rd_q_r;
  stage_t            out_r;
  logic [BYTE_W-1:0] out_byte_r;

  logic              out_free;
  logic              s1_free;
  logic              byte_last;
  logic              issue_byte;
  logic              issue_resp;
  logic              load_pop;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  assign out_free   = !out_valid_r || out_if.ready;
  assign s1_free    = !s1_valid_r || out_free;
  assign byte_last  = (idx_r == len_r - LEN_W'(1));
  assign issue_byte = (state_r == BK_STREAM) && s1_free;
  assign issue_resp = (state_r == BK_IDLE) && q_valid_i && !q_job_i.is_pop && s1_free;
  assign load_pop   = (state_r == BK_IDLE) && q_valid_i && q_job_i.is_pop;

  assign q_pop_o = issue_resp || load_pop;
  assign done_o  = issue_byte && byte_last;

  assign wr_addr = AW'(32'(wr_i.slot) * PACKET_BYTES + 32'(wr_i.pos));
  assign rd_addr = AW'(32'(cur_slot_r) * PACKET_BYTES + 32'(idx_r));

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.data;
    end
  end

  // Reads are issued only when the stage behind can take the byte, so the
  // read register holds its data for as long as the output stalls.
  always_ff @(posedge clk) begin
    if (issue_byte) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (load_pop) begin
            state_r <= BK_STREAM;
          end
        end
        BK_STREAM: begin
          if (done_o) begin
            state_r <= BK_IDLE;
          end
        end
        default: state_r <= BK_IDLE;
      endcase
      if (issue_byte || issue_resp) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pop) begin
      cur_slot_r <= SW'(q_job_i.slot);
      len_r      <= q_job_i.length;
      chan_r     <= q_job_i.channel;
      wait_r     <= q_job_i.waiting;
      idx_r      <= '0;
    end else if (issue_byte) begin
      idx_r <= idx_r + LEN_W'(1);
    end
    if (issue_byte) begin
      s1_r.status  <= ST_OK;
      s1_r.channel <= chan_r;
      s1_r.length  <= len_r;
      s1_r.waiting <= wait_r;
      s1_r.last    <= byte_last;
      s1_r.use_mem <= 1'b1;
    end else if (issue_resp) begin
      s1_r.status  <= q_job_i.status;
      s1_r.channel <= q_job_i.channel;
      s1_r.length  <= q_job_i.length;
      s1_r.waiting <= q_job_i.waiting;
      s1_r.last    <= 1'b1;
      s1_r.use_mem <= 1'b0;
    end
    if (out_free && s1_valid_r) begin
      out_r      <= s1_r;
      out_byte_r <= s1_r.use_mem ? rd_q_r : '0;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_r.status;
  assign out_if.out_byte       = out_byte_r;
  assign out_if.out_channel    = out_r.channel;
  assign out_if.out_length     = out_r.length;
  assign out_if.packet_waiting = out_r.waiting;
  assign out_if.last_of_run    = out_r.last;

  `SPQ_ASSERT_IMPL(a_stream_idx, state_r == BK_STREAM, idx_r < len_r, "read index past length")
  `SPQ_ASSERT_NEXT(a_stage_hold, s1_valid_r && !out_free, s1_valid_r, "stalled byte dropped")
  `SPQ_ASSERT_NEXT(a_done_idle, done_o, state_r == BK_IDLE, "read-out did not finish")

endmodule

// ===== src/send_packet_ring_queue.sv =====
// Channel   Direction  Fields
// in_if     input      op, data_byte, closes_packet, channel_tag
// out_if    output     status, out_byte, out_channel, out_length, packet_waiting, last_of_run
//
// A push or check, or a pop that finds no stored bytes, gives one result; a pop of a stored packet
// first loads its job, then streams one byte per cycle while the output is not stalled.
// A result passes through the job queue, the stage register and the output register.
// Requests stall while the job queue, which holds four requests, is full, or while the write
// slot is still being read out of the byte store.
// Reset is synchronous and active low; no clearing pass is needed.
// Top level: wires the front end, job queue and back end. Depends on spq_pkg and the interfaces.
module send_packet_ring_queue import spq_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  logic    q_push;
  job_t    q_job_in;
  logic    q_full;
  logic    q_valid;
  job_t    q_job_out;
  logic    q_pop;
  mem_wr_t mem_wr;
  logic    done;

  spq_front #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_job_in),
    .wr_o     (mem_wr),
    .done_i   (done)
  );

  spq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job_out),
    .pop_i   (q_pop)
  );

  spq_back #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (mem_wr),
    .q_valid_i (q_valid),
    .q_job_i   (q_job_out),
    .q_pop_o   (q_pop),
    .done_o    (done),
    .out_if    (out_if)
  );

endmodule
